// ===== rtl/qrw_pkg.sv =====
// Shared types, constants and helper functions of the QR module walker.
`default_nettype none
package qrw_pkg;

  localparam int MAX_SIDE = 41;
  localparam int ROW_W    = 41;
  localparam int ROW_AW   = 6;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;

  // Timing pattern: dark on even indices.
  localparam logic [ROW_W-1:0] TIMING_PAT = 41'h155_5555_5555;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP_RD,
    ST_SWEEP_EV,
    ST_FETCH,
    ST_FETCH_EV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       data_bit;
    logic       walk_done;
    logic [1:0] error_level;
    logic [2:0] mask_pattern;
    logic       timing_ok;
  } res_t;

  // Version clamped to 1..6, then side = 17 + 4 * version.
  function automatic logic [5:0] side_of(input logic [2:0] ver);
    logic [2:0] v;
    v = ver;
    if (v == 3'd0) v = 3'd1;
    if (v == 3'd7) v = 3'd6;
    return 6'd17 + {1'b0, v, 2'b00};
  endfunction

  function automatic logic [2:0] ver_eff(input logic [2:0] ver);
    logic [2:0] v;
    v = ver;
    if (v == 3'd0) v = 3'd1;
    if (v == 3'd7) v = 3'd6;
    return v;
  endfunction

  // Columns 8 .. side-9 of the timing row.
  function automatic logic [ROW_W-1:0] tim_mask(input logic [5:0] side);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (6'(i) >= 6'd8) && (6'(i) <= side - 6'd9);
    end
    return m;
  endfunction

  function automatic logic [1:0] mod3(input logic [5:0] x);
    logic [3:0] s;
    logic [2:0] s2;
    s  = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]};
    s2 = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    if (s2 >= 3'd3) s2 = s2 - 3'd3;
    return s2[1:0];
  endfunction

  // Reduce a value of 0..4 modulo 3.
  function automatic logic [1:0] red3(input logic [3:0] x);
    logic [3:0] t;
    t = (x >= 4'd3) ? x - 4'd3 : x;
    return t[1:0];
  endfunction

  function automatic logic is_func(input logic [5:0] r, input logic [5:0] c,
                                   input logic [5:0] side, input logic [2:0] ver);
    logic f;
    f = 1'b0;
    if (r <= 6'd8 && c >= side - 6'd8) f = 1'b1;
    if (ver >= 3'd2 && c >= side - 6'd9 && c <= side - 6'd5 &&
        r >= side - 6'd9 && r <= side - 6'd5) f = 1'b1;
    if (r == 6'd6 || c == 6'd6) f = 1'b1;
    if (r <= 6'd8 && c <= 6'd8) f = 1'b1;
    if (c <= 6'd8 && r >= side - 6'd8) f = 1'b1;
    return f;
  endfunction

  // Mask condition for row i, column j.
  function automatic logic mask_hit(input logic [5:0] i, input logic [5:0] j,
                                    input logic [2:0] m);
    logic [1:0]  a3;
    logic [1:0]  b3;
    logic [1:0]  pm3;
    logic [1:0]  sm3;
    logic [11:0] q;
    logic        p2;
    logic        h;
    a3  = mod3(i);
    b3  = mod3(j);
    pm3 = red3({2'b00, a3} * {2'b00, b3});
    sm3 = red3({2'b00, a3} + {2'b00, b3});
    q   = {6'd0, j} * 12'd43;   // q[7] is the parity of j / 3
    p2  = i[0] & j[0];
    case (m)
      3'd0:    h = ~(i[0] ^ j[0]);
      3'd1:    h = ~i[0];
      3'd2:    h = (b3 == 2'd0);
      3'd3:    h = (sm3 == 2'd0);
      3'd4:    h = ~(i[1] ^ q[7]);
      3'd5:    h = ~p2 && (pm3 == 2'd0);
      3'd6:    h = ~(p2 ^ pm3[0]);
      default: h = ~(i[0] ^ j[0] ^ pm3[0]);
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qr_module_walk_unmask.sv =====
// Top level of the QR module walker: ports, version register, result register.
// Every input beat yields exactly one result beat. A load beat (mode 0) writes one
// matrix row if its index lies inside the matrix. A start beat (mode 1) sweeps rows 6
// through side-1 of the matrix memory, reading and then evaluating each row. A fetch
// beat (mode 2) steps the walker one cell per cycle over function modules, then reads
// the data module from the matrix memory. The matrix memory has a single read port:
// one row read per cycle. One beat is in work at a time; a finished result sits in the
// output register so the next beat can be taken while it waits.
`default_nettype none
module qr_module_walk_unmask (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_mode,
  input  wire  [5:0]  in_row_index,
  input  wire  [40:0] in_row_modules,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_data_bit,
  output logic        out_walk_done,
  output logic [1:0]  out_error_level,
  output logic [2:0]  out_mask_pattern,
  output logic        out_timing_ok,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_symbol_version
);
  import qrw_pkg::*;

  logic [2:0]        ver_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r;
  res_t              res;
  logic              res_valid;
  logic              out_free;
  logic              busy;
  logic              mem_we, mem_re;
  logic [ROW_AW-1:0] mem_waddr, mem_raddr;
  logic [ROW_W-1:0]  mem_wdata, mem_rdata;

  // Version register; writes only land while idle.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      ver_r <= cfg_symbol_version;
    end
  end

  assign in_stall = busy;

  qrw_matrix u_matrix (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  qrw_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_go     (in_valid && !in_stall),
    .mode        (in_mode),
    .row_index   (in_row_index),
    .row_modules (in_row_modules),
    .version     (ver_r),
    .busy        (busy),
    .res_valid   (res_valid),
    .res_take    (out_free),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // Output register: free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_valid && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_bit     = out_r.data_bit;
  assign out_walk_done    = out_r.walk_done;
  assign out_error_level  = out_r.error_level;
  assign out_mask_pattern = out_r.mask_pattern;
  assign out_timing_ok    = out_r.timing_ok;

  // An accepted beat keeps the sequencer busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer not busy after accept");

  // A data bit is never reported once the walk has ended.
  a_bit_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data_bit && out_walk_done))
    else $error("data bit with walk done");

  // A result blocked by a full output register stays offered.
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_free |=> res_valid)
    else $error("pending result dropped");

endmodule
`default_nettype wire

// ===== rtl/qrw_matrix.sv =====
// Module matrix storage: one write port, one registered read port.
`default_nettype none
module qrw_matrix (
  input  wire                        clk,
  input  wire                        we,
  input  wire  [qrw_pkg::ROW_AW-1:0] waddr,
  input  wire  [qrw_pkg::ROW_W-1:0]  wdata,
  input  wire                        re,
  input  wire  [qrw_pkg::ROW_AW-1:0] raddr,
  output logic [qrw_pkg::ROW_W-1:0]  rdata
);
  import qrw_pkg::*;

  logic [ROW_W-1:0] mem [MAX_SIDE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qrw_walk.sv =====
// Sequencer: format/timing sweep, zigzag walker and unmasking.
`default_nettype none
module qrw_walk (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        item_go,
  input  wire  [1:0]                 mode,
  input  wire  [5:0]                 row_index,
  input  wire  [qrw_pkg::ROW_W-1:0]  row_modules,
  input  wire  [2:0]                 version,
  output logic                       busy,
  output logic                       res_valid,
  input  wire                        res_take,
  output qrw_pkg::res_t              res,
  output logic                       mem_we,
  output logic [qrw_pkg::ROW_AW-1:0] mem_waddr,
  output logic [qrw_pkg::ROW_W-1:0]  mem_wdata,
  output logic                       mem_re,
  output logic [qrw_pkg::ROW_AW-1:0] mem_raddr,
  input  wire  [qrw_pkg::ROW_W-1:0]  mem_rdata
);
  import qrw_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] col_r, col_nxt;
  logic [5:0] row_r, row_nxt;
  logic       up_r, up_nxt;
  logic       left_r, left_nxt;
  logic       fin_r, fin_nxt;
  logic [2:0] mask_r, mask_nxt;
  logic [1:0] level_r, level_nxt;
  logic       tim_r, tim_nxt;
  logic       tok_r, tok_nxt;
  logic [4:0] fb_r, fb_nxt;
  logic [5:0] srow_r, srow_nxt;
  logic       bit_r, bit_nxt;
  logic [5:0] dcol_r, dcol_nxt;
  logic [5:0] drow_r, drow_nxt;

  logic [5:0] side;
  logic [2:0] ver;
  logic [5:0] cur_c;
  logic [5:0] fidx;
  logic       oor;

  assign side  = side_of(version);
  assign ver   = ver_eff(version);
  assign cur_c = col_r - {5'd0, left_r};
  assign oor   = (col_r >= side) || (row_r >= side) || (left_r && col_r == 6'd0);
  assign fidx  = srow_r - (side - 6'd5);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      up_r    <= 1'b1;
      left_r  <= 1'b0;
      fin_r   <= 1'b1;
      mask_r  <= '0;
      level_r <= '0;
      tim_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      up_r    <= up_nxt;
      left_r  <= left_nxt;
      fin_r   <= fin_nxt;
      mask_r  <= mask_nxt;
      level_r <= level_nxt;
      tim_r   <= tim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    fb_r   <= fb_nxt;
    srow_r <= srow_nxt;
    bit_r  <= bit_nxt;
    dcol_r <= dcol_nxt;
    drow_r <= drow_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    up_nxt    = up_r;
    left_nxt  = left_r;
    fin_nxt   = fin_r;
    mask_nxt  = mask_r;
    level_nxt = level_r;
    tim_nxt   = tim_r;
    tok_nxt   = tok_r;
    fb_nxt    = fb_r;
    srow_nxt  = srow_r;
    bit_nxt   = bit_r;
    dcol_nxt  = dcol_r;
    drow_nxt  = drow_r;
    mem_we    = 1'b0;
    mem_waddr = row_index;
    mem_wdata = row_modules;
    mem_re    = 1'b0;
    mem_raddr = srow_r;
    res_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (item_go) begin
          bit_nxt = 1'b0;
          case (mode)
            MODE_LOAD: begin
              mem_we    = (row_index < 6'(MAX_SIDE));
              state_nxt = ST_EMIT;
            end
            MODE_START: begin
              srow_nxt  = 6'd6;
              tok_nxt   = 1'b1;
              state_nxt = ST_SWEEP_RD;
            end
            MODE_FETCH: state_nxt = ST_FETCH;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SWEEP_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_SWEEP_EV;
      end
      ST_SWEEP_EV: begin
        if (srow_r == 6'd6 &&
            ((mem_rdata & tim_mask(side)) != (TIMING_PAT & tim_mask(side)))) begin
          tok_nxt = 1'b0;
        end
        if (srow_r >= 6'd8 && srow_r <= side - 6'd9 && mem_rdata[6] == srow_r[0]) begin
          tok_nxt = 1'b0;
        end
        if (srow_r >= side - 6'd5) begin
          fb_nxt[fidx[2:0]] = mem_rdata[8];
        end
        if (srow_r == side - 6'd1) begin
          level_nxt = {~fb_nxt[4], fb_nxt[3]};
          mask_nxt  = {~fb_nxt[2], fb_nxt[1], ~fb_nxt[0]};
          tim_nxt   = tok_nxt;
          col_nxt   = side - 6'd1;
          row_nxt   = side - 6'd1;
          up_nxt    = 1'b1;
          left_nxt  = 1'b0;
          fin_nxt   = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          srow_nxt  = srow_r + 6'd1;
          state_nxt = ST_SWEEP_RD;
        end
      end
      ST_FETCH: begin
        if (fin_r) begin
          state_nxt = ST_EMIT;
        end else if (oor) begin
          fin_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          if (!is_func(row_r, cur_c, side, ver)) begin
            mem_re    = 1'b1;
            mem_raddr = row_r;
            drow_nxt  = row_r;
            dcol_nxt  = cur_c;
            state_nxt = ST_FETCH_EV;
          end
          // advance the walker one cell
          if (!left_r) begin
            left_nxt = 1'b1;
          end else begin
            left_nxt = 1'b0;
            if ((up_r && row_r == 6'd0) || (!up_r && row_r >= side - 6'd1)) begin
              if (col_r <= 6'd1) begin
                fin_nxt = 1'b1;
              end else begin
                col_nxt = (col_r == 6'd8) ? 6'd5 : col_r - 6'd2;
                up_nxt  = ~up_r;
              end
            end else if (up_r) begin
              row_nxt = row_r - 6'd1;
            end else begin
              row_nxt = row_r + 6'd1;
            end
          end
        end
      end
      ST_FETCH_EV: begin
        bit_nxt   = mem_rdata[dcol_r] ^ mask_hit(drow_r, dcol_r, mask_r);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign res.data_bit     = bit_r & ~fin_r;
  assign res.walk_done    = fin_r;
  assign res.error_level  = level_r;
  assign res.mask_pattern = mask_r;
  assign res.timing_ok    = tim_r;

endmodule
`default_nettype wire

// ===== tb/sv/qr_walk_checker.sv =====
// Checker for the QR module walker: predicts each result beat and compares it.
module qr_walk_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire [1:0]  in_mode,
  input  wire [5:0]  in_row_index,
  input  wire [40:0] in_row_modules,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire        out_data_bit,
  input  wire        out_walk_done,
  input  wire [1:0]  out_error_level,
  input  wire [2:0]  out_mask_pattern,
  input  wire        out_timing_ok,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [2:0]  cfg_symbol_version,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import qrw_pkg::*;

  bit [40:0] matrix [MAX_SIDE];
  bit [2:0]  version;
  int        pair_col;
  int        cur_row;
  bit        going_up;
  bit        on_left;
  bit        walk_over;
  int        mask_ref;
  int        level_bits;
  bit        timing_good;
  bit        fmt_key [15] = '{1, 0, 1, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0};
  res_t      predicted_beats [$];
  res_t      want_beat;
  res_t      seen_beat;

  function automatic bit in_function(int r, int c, int side, int v);
    if (r <= 8 && c >= side - 8) return 1;
    if (v >= 2 && c >= side - 9 && c <= side - 5 && r >= side - 9 && r <= side - 5)
      return 1;
    if (r == 6 || c == 6) return 1;
    if (r <= 8 && c <= 8) return 1;
    if (c <= 8 && r >= side - 8) return 1;
    return 0;
  endfunction

  function automatic bit masked(int i, int j);
    int p;
    p = i * j;
    case (mask_ref)
      0: return ((i + j) % 2) == 0;
      1: return (i % 2) == 0;
      2: return (j % 3) == 0;
      3: return ((i + j) % 3) == 0;
      4: return ((i / 2 + j / 3) % 2) == 0;
      5: return (p % 2 + p % 3) == 0;
      6: return ((p % 2 + p % 3) % 2) == 0;
      default: return (((i + j) % 2 + p % 3) % 2) == 0;
    endcase
  endfunction

  // One cell of the zigzag: right cell, then left cell, then move a row.
  function automatic void step_walk(int side);
    bit next_pair;
    next_pair = 0;
    if (!on_left) begin
      on_left = 1;
      return;
    end
    on_left = 0;
    if (going_up) begin
      if (cur_row == 0) next_pair = 1; else cur_row--;
    end else begin
      if (cur_row >= side - 1) next_pair = 1; else cur_row++;
    end
    if (next_pair) begin
      if (pair_col <= 1) begin
        walk_over = 1;
        return;
      end
      pair_col -= 2;
      if (pair_col == 6) pair_col = 5;
      going_up = !going_up;
    end
  endfunction

  function automatic bit next_data_bit(int side, int v);
    int c;
    bit b;
    while (!walk_over) begin
      if (pair_col >= side || cur_row >= side || (on_left && pair_col == 0)) begin
        walk_over = 1;
        break;
      end
      c = pair_col - (on_left ? 1 : 0);
      if (!in_function(cur_row, c, side, v)) begin
        b = matrix[cur_row][c] ^ masked(cur_row, c);
        step_walk(side);
        return b;
      end
      step_walk(side);
    end
    return 0;
  endfunction

  // Format bits from column 8, timing check, walker to bottom right.
  function automatic void begin_decode(int side);
    bit seq [15];
    bit f [15];
    int n;
    n = 0;
    for (int r = 0; r <= 8; r++) begin
      if (r != 6) begin
        seq[n] = matrix[r][8];
        n++;
      end
    end
    for (int r = side - 7; r <= side - 1; r++) begin
      seq[n] = matrix[r][8];
      n++;
    end
    for (int i = 0; i < 15; i++) f[i] = seq[14 - i] ^ fmt_key[i];
    level_bits = {f[0], f[1]};
    mask_ref = {f[2], f[3], f[4]};
    timing_good = 1;
    for (int i = 8; i <= side - 9; i++) begin
      if (matrix[6][i] != (i % 2 == 0) || matrix[i][6] != (i % 2 == 0)) timing_good = 0;
    end
    pair_col = side - 1;
    cur_row = side - 1;
    going_up = 1;
    on_left = 0;
    walk_over = 0;
  endfunction

  function automatic res_t walk_result(logic [1:0] m, logic [5:0] row, logic [40:0] mods);
    int v;
    int side;
    res_t r;
    v = version;
    if (v < 1) v = 1;
    if (v > 6) v = 6;
    side = 17 + 4 * v;
    r = '0;
    case (m)
      MODE_LOAD:  if (row < MAX_SIDE) matrix[row] = mods;
      MODE_START: begin_decode(side);
      MODE_FETCH: r.data_bit = next_data_bit(side, v);
      default: ;
    endcase
    if (walk_over) r.data_bit = 1'b0;
    r.walk_done = walk_over;
    r.error_level = level_bits[1:0];
    r.mask_pattern = mask_ref[2:0];
    r.timing_ok = timing_good;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      foreach (matrix[r]) matrix[r] = '0;
      version = 3'd1;
      pair_col = 0;
      cur_row = 0;
      going_up = 1;
      on_left = 0;
      walk_over = 1;
      mask_ref = 0;
      level_bits = 0;
      timing_good = 0;
      predicted_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) version = cfg_symbol_version;
      if (in_valid && !in_stall)
        predicted_beats.insert(predicted_beats.size(),
                               walk_result(in_mode, in_row_index, in_row_modules));
      if (out_valid && !out_stall) begin
        seen_beat = '{out_data_bit, out_walk_done, out_error_level, out_mask_pattern,
                      out_timing_ok};
        if (predicted_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", seen_beat);
        end else begin
          want_beat = predicted_beats.pop_front();
          if (seen_beat.data_bit !== want_beat.data_bit ||
              seen_beat.walk_done !== want_beat.walk_done ||
              seen_beat.error_level !== want_beat.error_level ||
              seen_beat.mask_pattern !== want_beat.mask_pattern ||
              seen_beat.timing_ok !== want_beat.timing_ok) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch at %0t: want %p got %p", $realtime, want_beat, seen_beat);
          end
        end
      end
    end
    pending = predicted_beats.size();
  end

endmodule

// ===== tb/sv/qr_module_walk_unmask_tb.sv =====
// Testbench top of the QR module walker: stimulus, idling, verdict.
module qr_module_walk_unmask_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qrw_pkg::*;

  // Unused mode code; the block reports held status only.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [1:0]  in_mode = MODE_LOAD;
  logic [5:0]  in_row_index = '0;
  logic [40:0] in_row_modules = '0;
  wire         out_valid;
  wire         out_stall;
  wire         out_data_bit;
  wire         out_walk_done;
  wire [1:0]   out_error_level;
  wire [2:0]   out_mask_pattern;
  wire         out_timing_ok;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic [2:0]  cfg_symbol_version = 3'd1;

  int fail_count;
  int pending;
  int beats_sent = 0;
  int cycles = 0;
  bit calm = 0;       // last part of the run: no idling

  // Receiver: random stall bursts, plus one long hold-off to fill the block.
  logic rand_stall = 1'b0;
  int   rand_left = 0;
  logic hold_stall = 1'b0;
  int   hold_cycles = 0;
  bit   hold_done = 0;
  assign out_stall = rand_stall | hold_stall;

  always #10 clk = ~clk;

  qr_module_walk_unmask DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_row_index(in_row_index), .in_row_modules(in_row_modules),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_bit(out_data_bit),
    .out_walk_done(out_walk_done), .out_error_level(out_error_level),
    .out_mask_pattern(out_mask_pattern), .out_timing_ok(out_timing_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_symbol_version(cfg_symbol_version)
  );

  qr_walk_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_row_index(in_row_index), .in_row_modules(in_row_modules),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_bit(out_data_bit),
    .out_walk_done(out_walk_done), .out_error_level(out_error_level),
    .out_mask_pattern(out_mask_pattern), .out_timing_ok(out_timing_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_symbol_version(cfg_symbol_version),
    .fail_count(fail_count), .pending(pending)
  );

  // Stall or not is drawn anew each time the burst counter reaches zero; it reloads with 1..19.
  always @(posedge clk) begin
    if (!rst_n) begin
      rand_stall <= 1'b0;
      rand_left <= 0;
    end else if (rand_left != 0) begin
      rand_left <= rand_left - 1;
    end else begin
      rand_stall <= !calm && ($urandom_range(0, 2) == 0);
      rand_left <= $urandom_range(1, 19);
    end
  end

  // Long hold-off once the stream is under way; sender keeps offering beats.
  always @(posedge clk) begin
    if (rst_n && !hold_done && beats_sent >= 300) begin
      hold_stall <= (hold_cycles != 400);
      hold_done <= (hold_cycles == 400);
      hold_cycles <= hold_cycles + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one beat, hold it until taken, then maybe leave a gap.
  task automatic send_beat(logic [1:0] m, logic [5:0] row, logic [40:0] mods);
    in_valid <= 1'b1;
    in_mode <= m;
    in_row_index <= row;
    in_row_modules <= mods;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  function automatic logic [40:0] rand_row();
    return {9'($urandom_range(0, 511)), 32'($urandom())};
  endfunction

  // Fresh matrix; with good timing, row 6 and column 6 alternate dark/light.
  task automatic load_matrix(bit good_timing);
    logic [40:0] r;
    for (int i = 0; i < MAX_SIDE; i++) begin
      r = rand_row();
      if (good_timing) begin
        if (i == 6) r = TIMING_PAT;
        else r[6] = (i % 2 == 0);
      end
      send_beat(MODE_LOAD, 6'(i), r);
    end
  endtask

  // Version register change, only with the block drained.
  task automatic set_version(logic [2:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_symbol_version <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic fetch_run(int n);
    repeat (n) send_beat(MODE_FETCH, 6'($urandom_range(0, 63)), rand_row());
  endtask

  logic [2:0] versions [12] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
                               3'd1, 3'd3, 3'd6, 3'd2};

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fetch before any start, spare mode, ignored out-of-range loads.
    send_beat(MODE_FETCH, 6'd0, '0);
    send_beat(MODE_SPARE, 6'd63, '1);
    send_beat(MODE_LOAD, 6'd63, '1);
    send_beat(MODE_LOAD, 6'd41, '0);
    load_matrix(1);
    send_beat(MODE_LOAD, 6'd40, '1);
    send_beat(MODE_LOAD, 6'd39, '0);
    send_beat(MODE_START, 6'd0, '0);
    fetch_run(8);
    send_beat(MODE_SPARE, 6'd0, '0);

    // Version 1 walked to the end and past it.
    set_version(3'd1);
    load_matrix($urandom_range(0, 3) != 0);
    send_beat(MODE_START, 6'd0, '0);
    fetch_run(215);

    foreach (versions[k]) begin
      if (k == 10) calm = 1;
      set_version(versions[k]);
      // Walker left outside a smaller symbol until the next start.
      fetch_run(3);
      load_matrix($urandom_range(0, 3) != 0);
      send_beat(MODE_START, 6'(k), rand_row());
      fetch_run($urandom_range(30, 60));
      send_beat(MODE_LOAD, 6'($urandom_range(41, 63)), rand_row());
      send_beat(MODE_SPARE, 6'($urandom_range(0, 63)), rand_row());
      // Restart mid-walk after a new row 0..5, which holds format bits in column 8.
      send_beat(MODE_LOAD, 6'($urandom_range(0, 5)), rand_row());
      send_beat(MODE_START, 6'd0, '0);
      fetch_run($urandom_range(15, 35));
    end
    set_version(3'd6);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
